@@ src/nfa_pkg.sv @@
// Package for the automaton word acceptor: item kinds, register indices,
// stream field positions and the lowest-set-bit helper.
// No dependencies; imported by the acceptor and its checker.
package nfa_pkg;

    typedef enum logic [1:0] {
        ACT_WR_MOVE  = 2'd0,
        ACT_WR_SPONT = 2'd1,
        ACT_START    = 2'd2,
        ACT_SYMBOL   = 2'd3
    } action_t;

    localparam logic [1:0] REG_STATE_COUNT   = 2'd0;
    localparam logic [1:0] REG_SYMBOL_COUNT  = 2'd1;
    localparam logic [1:0] REG_INITIAL_STATE = 2'd2;
    localparam logic [1:0] REG_FINAL_MASK    = 2'd3;

    localparam int SET_W       = 32;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    localparam int OUT_ACC_BIT   = 0;
    localparam int OUT_EMPTY_BIT = 1;
    localparam int OUT_BAD_BIT   = 2;
    localparam int OUT_SET_LSB   = 3;

    localparam logic [7:0] LETTER_BASE = 8'd97;

    function automatic logic [4:0] lowest_set(input logic [SET_W-1:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = SET_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ src/nfa_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; holds the transition and epsilon tables.
module nfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/nfa_word_acceptor.sv @@
// Top level of the automaton word acceptor: APB registers, stream handshake,
// sequencer and the two table RAMs. Depends on nfa_pkg and nfa_ram.
//
// Runs a nondeterministic automaton with epsilon moves, one letter per request.
// Table-write requests give no result. For a symbol request the transition
// RAM is read once per state active before the letter and the epsilon RAM
// once per state that enters the closure, one read per cycle. A state
// reached only through the epsilon row just read is expanded only after that
// row has been folded in. A start request runs the closure of the initial
// state alone, a bad letter skips both reads, and a result held back by
// m_tready holds the next one. After reset a clearing pass over every
// transition-table address zeroes both tables; no request is taken until it
// ends, while register writes are taken throughout.
module nfa_word_acceptor import nfa_pkg::*; #(
    parameter int MAX_STATES  = 32,
    parameter int MAX_LETTERS = 26
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request: s_tuser = action[1:0]
    // s_tdata = row_state[4:0], letter[12:5], row_mask[44:13], zero[47:45]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]             s_tuser,
    // result: m_tdata = accepted[0], set_empty[1], bad_letter[2],
    // active_states[34:3], zero[39:35]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int MOVE_DEPTH = MAX_STATES * MAX_LETTERS;
    localparam int MW         = $clog2(MOVE_DEPTH);
    localparam int SW         = $clog2(MAX_STATES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOVE,
        ST_CLOSE,
        ST_DONE
    } state_t;

    logic [5:0]       state_count_reg;
    logic [4:0]       symbol_count_reg;
    logic [4:0]       initial_state_reg;
    logic [SET_W-1:0] final_mask_reg;

    state_t                 state_reg, state_next;
    logic [MW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [SET_W-1:0]       active_reg, active_next;
    logic                   dead_reg, dead_next;
    logic [SET_W-1:0]       work_reg, work_next;
    logic [SET_W-1:0]       done_reg, done_next;
    logic [SET_W-1:0]       todo_reg, todo_next;
    logic                   busy_reg, busy_next;
    logic [4:0]             idx_reg, idx_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    action_t          in_action;
    logic [4:0]       in_row;
    logic [7:0]       in_letter;
    logic [SET_W-1:0] in_mask;
    logic [7:0]       letter_idx;
    logic             s_accept;
    logic             cfg_wr;

    logic [SET_W-1:0] live_mask;
    logic             init_live;
    logic             letter_bad;
    logic             wr_move_ok;
    logic             wr_spont_ok;

    logic [SET_W-1:0] pending;
    logic [SET_W-1:0] pick_src;
    logic [4:0]       pick;
    logic [SET_W-1:0] pick_bit;

    logic             move_we, spont_we;
    logic [MW-1:0]    move_waddr, move_raddr;
    logic [SW-1:0]    spont_waddr, spont_raddr;
    logic [SET_W-1:0] move_wdata, spont_wdata, move_rdata, spont_rdata;

    assign in_action  = action_t'(s_tuser);
    assign in_row     = s_tdata[4:0];
    assign in_letter  = s_tdata[12:5];
    assign in_mask    = s_tdata[44:13];
    assign letter_idx = in_letter - LETTER_BASE;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_count_reg   <= 6'd32;
            symbol_count_reg  <= 5'd26;
            initial_state_reg <= '0;
            final_mask_reg    <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_STATE_COUNT:   state_count_reg   <= pwdata[5:0];
                REG_SYMBOL_COUNT:  symbol_count_reg  <= pwdata[4:0];
                REG_INITIAL_STATE: initial_state_reg <= pwdata[4:0];
                REG_FINAL_MASK:    final_mask_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STATE_COUNT:   prdata = {26'd0, state_count_reg};
            REG_SYMBOL_COUNT:  prdata = {27'd0, symbol_count_reg};
            REG_INITIAL_STATE: prdata = {27'd0, initial_state_reg};
            REG_FINAL_MASK:    prdata = final_mask_reg;
            default:           prdata = '0;
        endcase
    end

    // clamp the state and letter counts, derive the live mask and checks
    always_comb begin
        int n;
        int nsym;
        n = int'(state_count_reg);
        if (n < 1) begin
            n = 1;
        end
        if (n > MAX_STATES) begin
            n = MAX_STATES;
        end
        nsym = int'(symbol_count_reg);
        if (nsym > MAX_LETTERS) begin
            nsym = MAX_LETTERS;
        end
        for (int i = 0; i < SET_W; i++) begin
            live_mask[i] = (i < n);
        end
        init_live   = int'(initial_state_reg) < n;
        letter_bad  = dead_reg || (in_letter < LETTER_BASE) || (int'(letter_idx) >= nsym);
        wr_move_ok  = (int'(in_row) < MAX_STATES) && (in_letter >= LETTER_BASE)
                      && (int'(letter_idx) < MAX_LETTERS);
        wr_spont_ok = int'(in_row) < MAX_STATES;
    end

    assign pending     = work_reg & ~done_reg & live_mask;
    assign pick_src    = (state_reg == ST_MOVE) ? todo_reg : pending;
    assign pick        = lowest_set(pick_src);
    assign pick_bit    = SET_W'(1) << pick;
    assign move_raddr  = MW'(int'(pick) * MAX_LETTERS + int'(idx_reg));
    assign spont_raddr = SW'(pick);

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        active_next   = active_reg;
        dead_next     = dead_reg;
        work_next     = work_reg;
        done_next     = done_reg;
        todo_next     = todo_reg;
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        move_we     = 1'b0;
        move_waddr  = MW'(int'(in_row) * MAX_LETTERS + int'(letter_idx));
        move_wdata  = in_mask;
        spont_we    = 1'b0;
        spont_waddr = SW'(in_row);
        spont_wdata = in_mask;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                move_we     = 1'b1;
                move_waddr  = clr_cnt_reg;
                move_wdata  = '0;
                spont_we    = int'(clr_cnt_reg) < MAX_STATES;
                spont_waddr = SW'(clr_cnt_reg);
                spont_wdata = '0;
                if (clr_cnt_reg == MW'(MOVE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_action)
                        ACT_WR_MOVE:  move_we  = wr_move_ok;
                        ACT_WR_SPONT: spont_we = wr_spont_ok;
                        ACT_START: begin
                            dead_next  = 1'b0;
                            work_next  = init_live ?
                                         ((SET_W'(1) << initial_state_reg) & live_mask) : '0;
                            done_next  = '0;
                            busy_next  = 1'b0;
                            state_next = ST_CLOSE;
                        end
                        ACT_SYMBOL: begin
                            if (letter_bad) begin
                                dead_next   = 1'b1;
                                active_next = '0;
                                state_next  = ST_DONE;
                            end else begin
                                todo_next  = active_reg & live_mask;
                                work_next  = '0;
                                busy_next  = 1'b0;
                                idx_next   = letter_idx[4:0];
                                state_next = ST_MOVE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOVE: begin
                // fold in the row read last cycle, issue the next active state
                if (busy_reg) begin
                    work_next = work_reg | move_rdata;
                end
                busy_next = (todo_reg != '0);
                if (todo_reg != '0) begin
                    todo_next = todo_reg & ~pick_bit;
                end else if (!busy_reg) begin
                    work_next  = work_reg & live_mask;
                    done_next  = '0;
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                // expand each newly reached state once through its epsilon row
                if (busy_reg) begin
                    work_next = work_reg | (spont_rdata & live_mask);
                end
                busy_next = (pending != '0);
                if (pending != '0) begin
                    done_next = done_reg | pick_bit;
                end else if (!busy_reg) begin
                    active_next = work_reg;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, active_reg, dead_reg, (active_reg == '0),
                                     (!dead_reg && ((active_reg & final_mask_reg) != '0))};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            active_reg   <= '0;
            dead_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            active_reg   <= active_next;
            dead_reg     <= dead_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        work_reg    <= work_next;
        done_reg    <= done_next;
        todo_reg    <= todo_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
    end

    nfa_ram #(
        .WIDTH (SET_W),
        .DEPTH (MOVE_DEPTH)
    ) u_move_ram (
        .clk   (aclk),
        .we    (move_we),
        .waddr (move_waddr),
        .wdata (move_wdata),
        .raddr (move_raddr),
        .rdata (move_rdata)
    );

    nfa_ram #(
        .WIDTH (SET_W),
        .DEPTH (MAX_STATES)
    ) u_spont_ram (
        .clk   (aclk),
        .we    (spont_we),
        .waddr (spont_waddr),
        .wdata (spont_wdata),
        .raddr (spont_raddr),
        .rdata (spont_rdata)
    );

endmodule

@@ src/nfa_chk.sv @@
// Port-level checker for the automaton word acceptor, bound to the top level.
// Depends on nfa_pkg for the result field positions.
module nfa_chk import nfa_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // empty flag must match the reported set
    a_empty_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_EMPTY_BIT] == (m_tdata[OUT_SET_LSB +: SET_W] == '0)))
        else $error("set_empty disagrees with active_states");

    // an empty set never accepts
    a_empty_rejects: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_EMPTY_BIT] |-> !m_tdata[OUT_ACC_BIT])
        else $error("empty set reported as accepted");

    // a dead word is empty and rejected
    a_dead_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_BAD_BIT] |-> m_tdata[OUT_EMPTY_BIT] && !m_tdata[OUT_ACC_BIT])
        else $error("bad letter result not empty");

    // ready must be low once reset has been sampled, as table clearing begins
    a_clear_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request taken during table clearing");

endmodule

bind nfa_word_acceptor nfa_chk u_nfa_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
